// ----- src/pilb_pkg.sv -----
package pilb_pkg;

    // Default list depth
    localparam int CAPACITY_DEF = 64;

    // Fixed field widths
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_AT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BACK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DUMP  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

endpackage

// ----- src/pilb_store.sv -----
module pilb_store
    import pilb_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = $clog2(CAPACITY_DEF)
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [ADDR_W-1:0]       i_raddr,
    output logic signed [VAL_W-1:0] o_rdata
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/positional_insert_list_buffer.sv -----
// Bounded ordered list of signed 32-bit words held in a single-port-write,
// registered-read memory, driven by a small sequencer that reuses one index
// counter for every step. An insert at target position p below the count
// first primes the read of the highest entry, then moves each entry from p
// upward one place, highest first (read and write overlapped on the memory
// ports), then writes the new word, then loads its status result once the
// output slot is free. An append goes straight to writing the new word, and a
// rejected insert straight to loading its status. A dump gives its entries in
// order, one per cycle while the output is not stalled. The input side is
// stalled from acceptance until the request's last result is loaded into the
// output register, so the next transfer can come in the cycle after that load;
// that result may still wait for the receiver while the next request is taken.
// Status: ok, bad position (position beyond the count, checked first), full,
// or empty (dump of an empty list, one result). The memory needs no clearing
// after reset: only entries below the count are ever read.
module positional_insert_list_buffer
    import pilb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_entry_value,
    output logic [ST_W-1:0]         o_status,
    output logic                    o_last_of_run
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_RESP  = 3'd3;
    localparam logic [2:0] S_DUMP  = 3'd4;

    logic [2:0]              r_state,  n_state;
    logic [CNT_W-1:0]        r_count,  n_count;
    logic [IDX_W-1:0]        r_idx,    n_idx;
    logic [IDX_W-1:0]        r_pos,    n_pos;
    logic                    r_pend,   n_pend;
    logic signed [VAL_W-1:0] r_val,    n_val;
    logic [ST_W-1:0]         r_st,     n_st;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic [ST_W-1:0]         r_out_status;
    logic                    r_out_last;

    // Memory port signals
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata;

    // Output load
    logic                    out_load;
    logic signed [VAL_W-1:0] out_value;
    logic [ST_W-1:0]         out_status;
    logic                    out_last;
    logic                    slot_free;

    // Shared index arithmetic
    logic [POS_W-1:0]        tgt_pos;
    logic [POS_W-1:0]        count_ext;
    logic                    is_full;
    logic [IDX_W-1:0]        idx_m1;
    logic [IDX_W-1:0]        idx_m2;
    logic [IDX_W-1:0]        idx_p1;
    logic [CNT_W-1:0]        cnt_m1;
    logic [IDX_W-1:0]        last_idx;

    pilb_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign count_ext = POS_W'(r_count);
    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign idx_m1    = r_idx - IDX_W'(1);
    assign idx_m2    = r_idx - IDX_W'(2);
    assign idx_p1    = r_idx + IDX_W'(1);
    assign cnt_m1    = r_count - CNT_W'(1);
    assign last_idx  = cnt_m1[IDX_W-1:0];
    assign slot_free = !r_out_valid || !i_out_stall;

    // Target position of an insert
    always_comb begin
        case (i_req_type)
            REQ_FRONT: tgt_pos = '0;
            REQ_AT:    tgt_pos = i_position;
            REQ_BACK:  tgt_pos = count_ext;
            default:   tgt_pos = count_ext;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_pend     = r_pend;
        n_val      = r_val;
        n_st       = r_st;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = idx_m1;
        out_load   = 1'b0;
        out_value  = '0;
        out_status = ST_OK;
        out_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_DUMP) begin
                        if (r_count == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_DUMP;
                        end
                    end else if (tgt_pos > count_ext) begin
                        n_st    = ST_BADPOS;
                        n_state = S_RESP;
                    end else if (is_full) begin
                        n_st    = ST_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_pos   = tgt_pos[IDX_W-1:0];
                        n_val   = i_new_value;
                        n_idx   = r_count[IDX_W-1:0];
                        n_pend  = 1'b0;
                        n_state = (tgt_pos == count_ext) ? S_PUT : S_SHIFT;
                    end
                end
            end

            // Move entries up one place, highest first; read of the next
            // source overlaps the write of the current one
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = mem_rdata;
                    n_idx     = idx_m1;
                    if (idx_m1 == r_pos) begin
                        n_pend  = 1'b0;
                        n_state = S_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_m2;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_m1;
                    n_pend    = 1'b1;
                end
            end

            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                n_count   = r_count + CNT_W'(1);
                n_st      = ST_OK;
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = r_st;
                    n_state    = S_IDLE;
                end
            end

            // Read data for r_idx is held until the output slot takes it
            S_DUMP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_value  = mem_rdata;
                    out_status = ST_OK;
                    out_last   = (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_p1;
                        n_idx     = idx_p1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_val <= n_val;
        r_st  <= n_st;
        if (out_load) begin
            r_out_value  <= out_value;
            r_out_status <= out_status;
            r_out_last   <= out_last;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;

endmodule

// ----- tb/tb_positional_insert_list_buffer.sv -----
module tb_positional_insert_list_buffer;
    import pilb_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int LATE_START   = 370;      // transfers accepted before idling stops
    localparam int HOLD_AT      = 60;       // accepted requests before the long out stall
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_WAIT   = 2 * LIST_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [REQ_W-1:0]        req;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
        bit                      drain_first;  // sender waits for an empty scoreboard
    } t_list_request;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [ST_W-1:0]         status;
        logic                    last;
    } t_list_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [REQ_W-1:0]        i_req_type = REQ_FRONT;
    logic signed [VAL_W-1:0] i_new_value = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [VAL_W-1:0] o_entry_value;
    logic [ST_W-1:0]         o_status;
    logic                    o_last_of_run;

    t_list_request           pending_requests[$];
    t_list_result            expected_results[$];
    logic signed [VAL_W-1:0] shadow_list[$];

    int  n_requests = 0;
    int  n_accepted = 0;
    int  fail_cnt = 0;
    int  cyc_cnt = 0;
    int  gen_count = 0;     // list length as seen by the stimulus generator
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  hold_rx = 1'b0;
    bit  hold_done = 1'b0;
    bit  all_drained = 1'b1;

    positional_insert_list_buffer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_new_value  (i_new_value),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_entry_value(o_entry_value),
        .o_status     (o_status),
        .o_last_of_run(o_last_of_run)
    );

    // Clock and reset
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
    end

    initial begin
        wait (cyc_cnt >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Idling allowed outside quiet windows and before the last part of the run
    function automatic bit idle_allowed();
        return (cyc_cnt[7:6] != 2'b11) && (n_accepted < LATE_START);
    endfunction

    // Expected results of one request; updates the shadow list
    task automatic predict_list_request(input logic [REQ_W-1:0] req,
                                        input logic signed [VAL_W-1:0] val,
                                        input logic [POS_W-1:0] pos);
        t_list_result res;
        int           target;
        res.value = '0;
        res.last  = 1'b1;
        if (req == REQ_DUMP) begin
            if (shadow_list.size() == 0) begin
                res.status = ST_EMPTY;
                expected_results.push_back(res);
            end else begin
                for (int i = 0; i < shadow_list.size(); i++) begin
                    res.value  = shadow_list[i];
                    res.status = ST_OK;
                    res.last   = (i == shadow_list.size() - 1);
                    expected_results.push_back(res);
                end
            end
        end else begin
            case (req)
                REQ_FRONT: target = 0;
                REQ_AT:    target = int'(pos);
                default:   target = shadow_list.size();
            endcase
            // position check wins over the full check
            if (target > shadow_list.size()) begin
                res.status = ST_BADPOS;
            end else if (shadow_list.size() >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_list.insert(target, val);
                res.status = ST_OK;
            end
            expected_results.push_back(res);
        end
    endtask

    // Queue one request for the driver, tracking the list length
    task automatic queue_request(input logic [REQ_W-1:0] req,
                                 input logic signed [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] pos,
                                 input bit drain);
        t_list_request item;
        item.req         = req;
        item.value       = val;
        item.pos         = pos;
        item.drain_first = drain;
        pending_requests.push_back(item);
        n_requests++;
        if (req != REQ_DUMP && gen_count < LIST_DEPTH &&
            !(req == REQ_AT && int'(pos) > gen_count)) begin
            gen_count++;
        end
    endtask

    // Stimulus: directed opening, then random requests
    initial begin : stimulus
        logic [REQ_W-1:0]        req;
        logic signed [VAL_W-1:0] val;
        logic [POS_W-1:0]        pos;
        int                      pick;

        queue_request(REQ_DUMP,  32'sh1234_5678, 7'd5, 1'b0);   // dump of empty list
        queue_request(REQ_FRONT, 32'sh7FFF_FFFF, 7'd0, 1'b0);
        queue_request(REQ_BACK,  32'sh8000_0000, 7'd64, 1'b0);
        queue_request(REQ_AT,    32'sh0000_0011, 7'd3, 1'b0);   // past the end
        queue_request(REQ_AT,    32'sh0000_0022, 7'd64, 1'b0);  // far past the end
        queue_request(REQ_AT,    -32'sd1,        7'd2, 1'b0);   // position == count
        queue_request(REQ_AT,    32'sh0000_0000, 7'd0, 1'b0);
        queue_request(REQ_AT,    32'sh5555_5555, 7'd1, 1'b0);
        queue_request(REQ_DUMP,  32'sh0,         7'd0, 1'b1);
        queue_request(REQ_FRONT, 32'shAAAA_AAAA, 7'd63, 1'b0);
        queue_request(REQ_BACK,  32'sh0000_0001, 7'd0, 1'b0);
        queue_request(REQ_AT,    32'shFFFF_FFFE, 7'd3, 1'b0);
        queue_request(REQ_AT,    32'sh8000_0001, 7'd9, 1'b0);   // past the end
        queue_request(REQ_AT,    32'sh7FFF_FFFE, 7'd8, 1'b0);   // append by position
        queue_request(REQ_DUMP,  -32'sd1,        7'd127 & 7'd64, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)      req = REQ_DUMP;
            else if (pick < 40) req = REQ_FRONT;
            else if (pick < 75) req = REQ_AT;
            else                req = REQ_BACK;

            case ($urandom_range(0, 9))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7FFF_FFFF;
                2:       val = -32'sd1;
                3:       val = 32'sd0;
                default: val = $urandom;
            endcase

            if (req == REQ_AT) begin
                if (gen_count < LIST_DEPTH && $urandom_range(0, 3) == 0)
                    pos = POS_W'($urandom_range(gen_count + 1, LIST_DEPTH));
                else
                    pos = POS_W'($urandom_range(0, gen_count));
            end else begin
                pos = POS_W'($urandom_range(0, LIST_DEPTH));
            end

            queue_request(req, val, pos, n == 180);
        end

        // end of run: everything accepted, every result seen, then a quiet tail
        do @(negedge i_clk);
        while (n_accepted != n_requests || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Request driver
    always @(posedge i_clk) begin : drive_requests
        t_list_request item;
        bit            took_now;
        if (i_rst_n) begin
            took_now = i_in_valid && !o_in_stall;
            if (i_in_valid && !took_now) begin
                // stalled: payload holds
            end else if (tx_gap != 0) begin
                tx_gap     <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_requests[0].drain_first && (took_now || !all_drained)) begin
                i_in_valid <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
                tx_gap     <= $urandom_range(0, 2);
                i_in_valid <= 1'b0;
            end else begin
                item = pending_requests.pop_front();
                i_req_type  <= item.req;
                i_new_value <= item.value;
                i_position  <= item.pos;
                i_in_valid  <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_rx <= 1'b0;
        end else if (!hold_done && n_accepted == HOLD_AT) begin
            hold_rx   <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Monitor: predict on input transfers, check output transfers, drive out stall
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        bit           stall_next;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: entry_value %0d status %0d last %0b",
                           o_entry_value, o_status, o_last_of_run);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_entry_value !== want.value) begin
                        $error("entry_value: expected %0d, got %0d", want.value, o_entry_value);
                        fail_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_cnt++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                        fail_cnt++;
                    end
                end
            end

            if (i_in_valid && !o_in_stall) begin
                predict_list_request(i_req_type, i_new_value, i_position);
                n_accepted <= n_accepted + 1;
            end
            all_drained <= (expected_results.size() == 0);

            // random stall bursts
            if (rx_gap != 0) begin
                rx_gap     <= rx_gap - 1;
                stall_next = 1'b1;
            end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                rx_gap     <= $urandom_range(0, 2);
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            i_out_stall <= stall_next || hold_rx;
        end
    end

endmodule

// ----- sim.f -----
src/pilb_pkg.sv
src/pilb_store.sv
src/positional_insert_list_buffer.sv
tb/tb_positional_insert_list_buffer.sv
